>>> hw/rtl/urm_pkg.sv
`default_nettype none
package urm_pkg;

	localparam int HISTORY_DEPTH = 3;

	localparam int DIST_W     = 13;
	localparam int TIMER_W    = 15;
	localparam int SINCE_W    = 20;
	localparam int STATUS_W   = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PING_INTERVAL = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RISE_TIMEOUT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_TIMEOUT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_DISTANCE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_DISTANCE  = 3'd4;

	// register reset values
	localparam logic [SINCE_W-1:0] PING_INTERVAL_RST = 20'd60000;
	localparam logic [TIMER_W-1:0] RISE_TIMEOUT_RST  = 15'd5000;
	localparam logic [TIMER_W-1:0] HIGH_TIMEOUT_RST  = 15'd25000;
	localparam logic [DIST_W-1:0]  MIN_DISTANCE_RST  = 13'd32;
	localparam logic [DIST_W-1:0]  MAX_DISTANCE_RST  = 13'd6400;

	// ping status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_ECHO_BUSY = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NO_RISE   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NO_ECHO   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd4;

	// trigger pulse shape and distance scale
	localparam logic [TIMER_W-1:0] TRIG_LOW_TICKS  = 15'd2;
	localparam logic [TIMER_W-1:0] TRIG_HIGH_TICKS = 15'd10;
	localparam int                 PROD_W          = 24;
	localparam logic [PROD_W-1:0]  DIST_MULT       = 24'd281;
	localparam int                 DIST_SHIFT      = 10;

	typedef struct packed {
		logic [SINCE_W-1:0] ping_interval;
		logic [TIMER_W-1:0] rise_timeout;
		logic [TIMER_W-1:0] high_timeout;
		logic [DIST_W-1:0]  min_distance;
		logic [DIST_W-1:0]  max_distance;
	} cfg_t;

	typedef struct packed {
		logic                finish;
		logic [STATUS_W-1:0] status;
		logic [DIST_W-1:0]   dist_q4;
	} finish_t;

endpackage
`default_nettype wire

>>> hw/rtl/urm_if.sv
`default_nettype none
interface urm_item_if;
	logic valid;
	logic ready;
	logic echo_level;
	logic request;

	modport source (output valid, output echo_level, output request, input ready);
	modport sink (input valid, input echo_level, input request, output ready);
endinterface

interface urm_result_if;
	logic                          valid;
	logic                          ready;
	logic                          trig_level;
	logic                          busy_res;
	logic                          reply_valid;
	logic [urm_pkg::DIST_W-1:0]    distance_q4;
	logic                          distance_ok;
	logic                          fresh_ping;
	logic [urm_pkg::STATUS_W-1:0]  ping_status;

	modport source (output valid, output trig_level, output busy_res, output reply_valid,
		output distance_q4, output distance_ok, output fresh_ping, output ping_status,
		input ready);
	modport sink (input valid, input trig_level, input busy_res, input reply_valid,
		input distance_q4, input distance_ok, input fresh_ping, input ping_status,
		output ready);
endinterface
`default_nettype wire

>>> hw/rtl/urm_seq.sv
`default_nettype none
module urm_seq (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire logic              echo,
	input  wire logic              req,
	input  wire urm_pkg::cfg_t     cfg,
	output logic                   trig,
	output logic                   busy,
	output logic                   reply,
	output logic                   fresh,
	output urm_pkg::finish_t       fin
);

	localparam logic [2:0] PH_IDLE      = 3'd0;
	localparam logic [2:0] PH_TRIG_LOW  = 3'd1;
	localparam logic [2:0] PH_TRIG_HIGH = 3'd2;
	localparam logic [2:0] PH_WAIT_RISE = 3'd3;
	localparam logic [2:0] PH_MEASURE   = 3'd4;

	logic [2:0]                     phase_q, phase_d;
	logic [urm_pkg::TIMER_W-1:0]    timer_q, timer_d, timer_inc;
	logic [urm_pkg::SINCE_W-1:0]    since_q, since_d, since_inc;
	logic                           pinged_q, pinged_d;
	logic [urm_pkg::PROD_W-1:0]     prod;
	logic [urm_pkg::DIST_W:0]       dist_wide;

	assign timer_inc = timer_q + urm_pkg::TIMER_W'(1);
	assign since_inc = (since_q != '1) ? since_q + urm_pkg::SINCE_W'(1) : since_q;
	assign prod      = urm_pkg::PROD_W'(timer_q) * urm_pkg::DIST_MULT;
	assign dist_wide = prod[urm_pkg::DIST_SHIFT +: urm_pkg::DIST_W+1];

	always_comb begin
		phase_d     = phase_q;
		timer_d     = timer_q;
		since_d     = since_inc;
		pinged_d    = pinged_q;
		trig        = 1'b0;
		reply       = 1'b0;
		fresh       = 1'b0;
		fin.finish  = 1'b0;
		fin.status  = urm_pkg::ST_OK;
		fin.dist_q4 = '0;
		case (phase_q)
			PH_TRIG_LOW: begin
				timer_d = timer_inc;
				if (timer_inc >= urm_pkg::TRIG_LOW_TICKS) begin
					phase_d = PH_TRIG_HIGH;
					timer_d = '0;
				end
			end
			PH_TRIG_HIGH: begin
				trig    = 1'b1;
				timer_d = timer_inc;
				if (timer_inc >= urm_pkg::TRIG_HIGH_TICKS) begin
					phase_d = PH_WAIT_RISE;
					timer_d = '0;
				end
			end
			PH_WAIT_RISE: begin
				if (echo) begin
					phase_d = PH_MEASURE;
					timer_d = urm_pkg::TIMER_W'(1);
				end else if (timer_q >= cfg.rise_timeout) begin
					fin.finish = 1'b1;
					fin.status = urm_pkg::ST_NO_RISE;
				end else begin
					timer_d = timer_inc;
				end
			end
			PH_MEASURE: begin
				if (!echo) begin
					fin.finish = 1'b1;
					if (dist_wide < {1'b0, cfg.min_distance}
							|| dist_wide > {1'b0, cfg.max_distance}) begin
						fin.status = urm_pkg::ST_RANGE;
					end else begin
						fin.dist_q4 = dist_wide[urm_pkg::DIST_W-1:0];
					end
				end else if (timer_q >= cfg.high_timeout) begin
					fin.finish = 1'b1;
					fin.status = urm_pkg::ST_NO_ECHO;
				end else begin
					timer_d = timer_inc;
				end
			end
			default: begin
				phase_d = PH_IDLE;
				timer_d = '0;
				if (req) begin
					if (pinged_q && since_inc < cfg.ping_interval) begin
						reply = 1'b1;
					end else begin
						since_d  = '0;
						pinged_d = 1'b1;
						if (echo) begin
							fin.finish = 1'b1;
							fin.status = urm_pkg::ST_ECHO_BUSY;
						end else begin
							phase_d = PH_TRIG_LOW;
							timer_d = urm_pkg::TIMER_W'(1);
						end
					end
				end
			end
		endcase
		if (fin.finish) begin
			phase_d = PH_IDLE;
			timer_d = '0;
			reply   = 1'b1;
			fresh   = 1'b1;
		end
		busy = (phase_d != PH_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			timer_q  <= '0;
			since_q  <= '0;
			pinged_q <= 1'b0;
		end else if (step) begin
			phase_q  <= phase_d;
			timer_q  <= timer_d;
			since_q  <= since_d;
			pinged_q <= pinged_d;
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/urm_filt.sv
`default_nettype none
module urm_filt #(
	parameter int HISTORY_DEPTH = urm_pkg::HISTORY_DEPTH
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          step,
	input  wire urm_pkg::finish_t              fin,
	output logic [urm_pkg::DIST_W-1:0]         value,
	output logic                               value_ok,
	output logic [urm_pkg::STATUS_W-1:0]       status
);

	localparam int PW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int CW = $clog2(HISTORY_DEPTH + 1);

	logic [urm_pkg::DIST_W-1:0]   hv_q [HISTORY_DEPTH];
	logic [urm_pkg::DIST_W-1:0]   hv_d [HISTORY_DEPTH];
	logic [HISTORY_DEPTH-1:0]     hok_q, hok_d;
	logic [PW-1:0]                pos_q, pos_d;
	logic [urm_pkg::STATUS_W-1:0] status_q;
	logic [CW-1:0]                cnt;
	logic [CW-1:0]                rank [HISTORY_DEPTH];

	always_comb begin
		for (int i = 0; i < HISTORY_DEPTH; i++) begin
			hv_d[i]  = hv_q[i];
			hok_d[i] = hok_q[i];
			if (fin.finish && pos_q == PW'(i)) begin
				hok_d[i] = (fin.status == urm_pkg::ST_OK);
				hv_d[i]  = (fin.status == urm_pkg::ST_OK) ? fin.dist_q4 : '0;
			end
		end
		pos_d = pos_q;
		if (fin.finish) begin
			pos_d = (pos_q >= PW'(HISTORY_DEPTH - 1)) ? '0 : pos_q + PW'(1);
		end
	end

	// median by rank: ties broken by slot index
	always_comb begin
		cnt = '0;
		for (int i = 0; i < HISTORY_DEPTH; i++) begin
			cnt = cnt + CW'(hok_d[i]);
		end
		for (int i = 0; i < HISTORY_DEPTH; i++) begin
			rank[i] = '0;
			for (int j = 0; j < HISTORY_DEPTH; j++) begin
				if (hok_d[j] && (hv_d[j] < hv_d[i] || (hv_d[j] == hv_d[i] && j < i))) begin
					rank[i] = rank[i] + CW'(1);
				end
			end
		end
		value    = '0;
		value_ok = (cnt != '0);
		for (int i = 0; i < HISTORY_DEPTH; i++) begin
			if (hok_d[i] && rank[i] == (cnt >> 1)) begin
				value = hv_d[i];
			end
		end
	end

	assign status = fin.finish ? fin.status : status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hok_q    <= '0;
			pos_q    <= '0;
			status_q <= urm_pkg::ST_OK;
			for (int i = 0; i < HISTORY_DEPTH; i++) begin
				hv_q[i] <= '0;
			end
		end else if (step) begin
			hok_q    <= hok_d;
			pos_q    <= pos_d;
			status_q <= status;
			for (int i = 0; i < HISTORY_DEPTH; i++) begin
				hv_q[i] <= hv_d[i];
			end
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/ultrasonic_ranging_median_top.sv
`default_nettype none
// Ultrasonic echo ranger with a median filter over the last HISTORY_DEPTH pings.
// Each request on item carries one microsecond tick (echo pin sample and a request
// flag); each one yields exactly one request on result, registered, valid in the cycle
// after the item is taken. A new item is taken in every cycle in which the output
// register is empty or its result is taken at the same edge, so items can follow back
// to back; a result held back by result.ready stalls item. The only latency is that
// single output stage. Configuration writes (cfg_we, cfg_idx, cfg_wdata) are meant
// for idle periods.
module ultrasonic_ranging_median_top #(
	parameter int HISTORY_DEPTH = urm_pkg::HISTORY_DEPTH
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [urm_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  wire logic [urm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	urm_item_if.sink                                item,
	urm_result_if.source                            result
);

	urm_pkg::cfg_t                 cfg_q;
	urm_pkg::finish_t              fin;
	logic                          step;
	logic                          trig, busy, reply, fresh;
	logic [urm_pkg::DIST_W-1:0]    value;
	logic                          value_ok;
	logic [urm_pkg::STATUS_W-1:0]  status;
	logic                          out_v_q;

	assign item.ready = !out_v_q || result.ready;
	assign step       = item.valid && item.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ping_interval <= urm_pkg::PING_INTERVAL_RST;
			cfg_q.rise_timeout  <= urm_pkg::RISE_TIMEOUT_RST;
			cfg_q.high_timeout  <= urm_pkg::HIGH_TIMEOUT_RST;
			cfg_q.min_distance  <= urm_pkg::MIN_DISTANCE_RST;
			cfg_q.max_distance  <= urm_pkg::MAX_DISTANCE_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				urm_pkg::REG_PING_INTERVAL: cfg_q.ping_interval <= cfg_wdata;
				urm_pkg::REG_RISE_TIMEOUT:
					cfg_q.rise_timeout <= cfg_wdata[urm_pkg::TIMER_W-1:0];
				urm_pkg::REG_HIGH_TIMEOUT:
					cfg_q.high_timeout <= cfg_wdata[urm_pkg::TIMER_W-1:0];
				urm_pkg::REG_MIN_DISTANCE:
					cfg_q.min_distance <= cfg_wdata[urm_pkg::DIST_W-1:0];
				urm_pkg::REG_MAX_DISTANCE:
					cfg_q.max_distance <= cfg_wdata[urm_pkg::DIST_W-1:0];
				default: begin
				end
			endcase
		end
	end

	urm_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.echo   (item.echo_level),
		.req    (item.request),
		.cfg    (cfg_q),
		.trig   (trig),
		.busy   (busy),
		.reply  (reply),
		.fresh  (fresh),
		.fin    (fin)
	);

	urm_filt #(
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_filt (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.fin      (fin),
		.value    (value),
		.value_ok (value_ok),
		.status   (status)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (step) begin
			out_v_q <= 1'b1;
		end else if (result.ready) begin
			out_v_q <= 1'b0;
		end
	end

	logic                          trig_q, busy_q, reply_q, ok_q, fresh_q;
	logic [urm_pkg::DIST_W-1:0]    dist_q;
	logic [urm_pkg::STATUS_W-1:0]  status_q;

	always_ff @(posedge clk) begin
		if (step) begin
			trig_q   <= trig;
			busy_q   <= busy;
			reply_q  <= reply;
			dist_q   <= value;
			ok_q     <= value_ok;
			fresh_q  <= fresh;
			status_q <= status;
		end
	end

	assign result.valid       = out_v_q;
	assign result.trig_level  = trig_q;
	assign result.busy_res    = busy_q;
	assign result.reply_valid = reply_q;
	assign result.distance_q4 = dist_q;
	assign result.distance_ok = ok_q;
	assign result.fresh_ping  = fresh_q;
	assign result.ping_status = status_q;

endmodule
`default_nettype wire
